FILE: rtl/swft_pkg.sv
// Shared types and constants for the single-wire frame transmitter.
package swft_pkg;

  localparam int FRAME_W = 10;
  localparam int LEN_W   = 4;
  localparam int TICK_W  = 8;
  localparam int LIMIT_W = 4;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] DATA_START = 2'd2;

  localparam logic [LEN_W-1:0] CMD_FRAME_LEN  = 4'd5;
  localparam logic [LEN_W-1:0] DATA_FRAME_LEN = 4'd10;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_LONG_TICKS   = 3'd0;
  localparam logic [2:0] REG_SHORT_TICKS  = 3'd1;
  localparam logic [2:0] REG_ACK_SAMPLE   = 3'd2;
  localparam logic [2:0] REG_RETRY_GAP    = 3'd3;
  localparam logic [2:0] REG_RETRY_LIMIT  = 3'd4;

  localparam logic [TICK_W-1:0]  LONG_TICKS_RST  = 8'd40;
  localparam logic [TICK_W-1:0]  SHORT_TICKS_RST = 8'd4;
  localparam logic [TICK_W-1:0]  ACK_SAMPLE_RST  = 8'd24;
  localparam logic [TICK_W-1:0]  RETRY_GAP_RST   = 8'd16;
  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = 4'd1;

  typedef struct packed {
    logic [TICK_W-1:0]  long_ticks;
    logic [TICK_W-1:0]  short_ticks;
    logic [TICK_W-1:0]  ack_sample_ticks;
    logic [TICK_W-1:0]  retry_gap_ticks;
    logic [LIMIT_W-1:0] retry_limit;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic               is_start;
    logic [FRAME_W-1:0] frame;
    logic [LEN_W-1:0]   length;
    logic               line_level;
  } entry_t;

  typedef struct packed {
    logic drive_low;
    logic line_driven;
    logic busy_res;
    logic frame_done;
    logic frame_failed;
    logic start_rejected;
  } result_t;

endpackage

FILE: rtl/swft_front.sv
// Front end: decodes a request and builds its frame image ahead of the engine.
module swft_front (
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_payload,
  input  logic              in_line_level,
  output swft_pkg::entry_t  entry
);

  logic       cmd_par;
  logic       data_par;
  logic [2:0] code;

  assign code     = in_payload[2:0];
  assign cmd_par  = ^code;
  assign data_par = ^in_payload;

  always_comb begin
    entry            = '0;
    entry.line_level = in_line_level;
    case (in_command)
      swft_pkg::CMD_START: begin
        entry.is_start = 1'b1;
        // header 0, code, parity, left aligned
        entry.frame    = {1'b0, code, cmd_par, 5'b00000};
        entry.length   = swft_pkg::CMD_FRAME_LEN;
      end
      swft_pkg::DATA_START: begin
        entry.is_start = 1'b1;
        entry.frame    = {1'b0, in_payload, data_par};
        entry.length   = swft_pkg::DATA_FRAME_LEN;
      end
      default: begin
        entry.is_start = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/swft_queue.sv
// Small request queue between front and back.
module swft_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swft_pkg::entry_t  push_data,
  output logic              full,
  input  logic              pop,
  output swft_pkg::entry_t  pop_data,
  output logic              not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  swft_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/swft_back.sv
// Back end: bit timing, acknowledge sampling and retry sequencing, with output register.
module swft_back (
  input  logic              clk,
  input  logic              rst_n,
  input  swft_pkg::cfg_t    cfg,
  input  logic              ent_valid,
  input  swft_pkg::entry_t  ent,
  output logic              ent_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output swft_pkg::result_t out_res
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LOW   = 3'd1,
    PH_HIGH  = 3'd2,
    PH_EDGE  = 3'd3,
    PH_DELAY = 3'd4,
    PH_GAP   = 3'd5
  } phase_t;

  localparam int FW = swft_pkg::FRAME_W;
  localparam int LW = swft_pkg::LEN_W;
  localparam int TW = swft_pkg::TICK_W;
  localparam int RW = swft_pkg::LIMIT_W;

  phase_t          phase_r, phase_nxt;
  logic [FW-1:0]   frame_bits_r, frame_bits_nxt;
  logic [FW-1:0]   saved_frame_r, saved_frame_nxt;
  logic [LW-1:0]   frame_length_r, frame_length_nxt;
  logic [LW-1:0]   bits_left_r, bits_left_nxt;
  logic [TW-1:0]   tick_count_r, tick_count_nxt;
  logic [RW-1:0]   attempts_left_r, attempts_left_nxt;
  logic            out_valid_r;
  swft_pkg::result_t out_res_r, res_nxt;

  logic            cur_bit;
  logic [TW-1:0]   tick_inc;
  logic [TW-1:0]   low_len, high_len, ack_len, gap_len;

  function automatic logic [TW-1:0] min_one8(input logic [TW-1:0] v);
    return (v == '0) ? TW'(1) : v;
  endfunction

  function automatic logic [RW-1:0] min_one4(input logic [RW-1:0] v);
    return (v == '0) ? RW'(1) : v;
  endfunction

  assign ent_pop   = ent_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign ack_len = min_one8(cfg.ack_sample_ticks);
  assign gap_len = min_one8(cfg.retry_gap_ticks);

  always_comb begin
    phase_nxt         = phase_r;
    frame_bits_nxt    = frame_bits_r;
    saved_frame_nxt   = saved_frame_r;
    frame_length_nxt  = frame_length_r;
    bits_left_nxt     = bits_left_r;
    tick_count_nxt    = tick_count_r;
    attempts_left_nxt = attempts_left_r;
    res_nxt           = '0;

    if (ent.is_start) begin
      if (phase_r == PH_IDLE) begin
        saved_frame_nxt   = ent.frame;
        frame_length_nxt  = ent.length;
        frame_bits_nxt    = ent.frame;
        bits_left_nxt     = ent.length;
        attempts_left_nxt = min_one4(cfg.retry_limit);
        tick_count_nxt    = '0;
        phase_nxt         = PH_LOW;
      end else begin
        res_nxt.start_rejected = 1'b1;
      end
    end

    // timing uses the (possibly just loaded) frame
    cur_bit  = frame_bits_nxt[FW-1];
    low_len  = min_one8(cur_bit ? cfg.short_ticks : cfg.long_ticks);
    high_len = min_one8(cur_bit ? cfg.long_ticks : cfg.short_ticks);
    tick_inc = tick_count_nxt + TW'(1);

    case (phase_nxt)
      PH_LOW: begin
        res_nxt.drive_low   = 1'b1;
        res_nxt.line_driven = 1'b1;
        res_nxt.busy_res    = 1'b1;
        tick_count_nxt      = tick_inc;
        if (tick_inc >= low_len) begin
          tick_count_nxt = '0;
          phase_nxt      = PH_HIGH;
        end
      end
      PH_HIGH: begin
        res_nxt.line_driven = 1'b1;
        res_nxt.busy_res    = 1'b1;
        tick_count_nxt      = tick_inc;
        if (tick_inc >= high_len) begin
          tick_count_nxt = '0;
          frame_bits_nxt = {frame_bits_nxt[FW-2:0], 1'b0};
          if (bits_left_nxt != '0) begin
            bits_left_nxt = bits_left_nxt - LW'(1);
          end
          phase_nxt = (bits_left_nxt != '0) ? PH_LOW : PH_EDGE;
        end
      end
      PH_EDGE: begin
        res_nxt.busy_res = 1'b1;
        if (!ent.line_level) begin
          tick_count_nxt = '0;
          phase_nxt      = PH_DELAY;
        end
      end
      PH_DELAY: begin
        res_nxt.busy_res = 1'b1;
        tick_count_nxt   = tick_inc;
        if (tick_inc >= ack_len) begin
          tick_count_nxt = '0;
          if (ent.line_level) begin
            res_nxt.frame_done = 1'b1;
            phase_nxt          = PH_IDLE;
          end else begin
            if (attempts_left_nxt != '0) begin
              attempts_left_nxt = attempts_left_nxt - RW'(1);
            end
            if (attempts_left_nxt == '0) begin
              res_nxt.frame_done   = 1'b1;
              res_nxt.frame_failed = 1'b1;
              phase_nxt            = PH_IDLE;
            end else begin
              phase_nxt = PH_GAP;
            end
          end
        end
      end
      PH_GAP: begin
        res_nxt.busy_res = 1'b1;
        tick_count_nxt   = tick_inc;
        if (tick_inc >= gap_len) begin
          tick_count_nxt = '0;
          frame_bits_nxt = saved_frame_nxt;
          bits_left_nxt  = frame_length_nxt;
          phase_nxt      = PH_LOW;
        end
      end
      default: begin
        res_nxt.line_driven = 1'b1;
        phase_nxt           = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      frame_bits_r    <= '0;
      saved_frame_r   <= '0;
      frame_length_r  <= '0;
      bits_left_r     <= '0;
      tick_count_r    <= '0;
      attempts_left_r <= '0;
      out_valid_r     <= 1'b0;
      out_res_r       <= '0;
    end else begin
      if (ent_pop) begin
        phase_r         <= phase_nxt;
        frame_bits_r    <= frame_bits_nxt;
        saved_frame_r   <= saved_frame_nxt;
        frame_length_r  <= frame_length_nxt;
        bits_left_r     <= bits_left_nxt;
        tick_count_r    <= tick_count_nxt;
        attempts_left_r <= attempts_left_nxt;
        out_res_r       <= res_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/single_wire_frame_transmitter_top.sv
// Top level of the single-wire frame transmitter: APB registers, front, queue and back.
//
// Every input request is one tick of line time and yields exactly one result
// describing that tick, so the block takes one request per clock while the
// queue is not full. A request lands in a short queue after decoding and moves
// into the output register once that register is empty or being emptied; the
// back end updates its phase and tick counter as each request moves, which sets
// that rate. The queue absorbs up to QUEUE_DEPTH requests, plus the one held in
// the output register, while the result side stalls.
// Registers are written over APB at byte address 4*index and read back the
// same way; tick registers and the retry limit treat zero as one.
module single_wire_frame_transmitter_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_payload,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drive_low,
  output logic        out_line_driven,
  output logic        out_busy_res,
  output logic        out_frame_done,
  output logic        out_frame_failed,
  output logic        out_start_rejected,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [swft_pkg::ADDR_W-1:0] paddr,
  input  logic [swft_pkg::DATA_W-1:0] pwdata,
  output logic [swft_pkg::DATA_W-1:0] prdata,
  output logic        pready
);

  localparam int DW = swft_pkg::DATA_W;

  swft_pkg::cfg_t    cfg_r;
  swft_pkg::entry_t  front_entry, q_entry;
  swft_pkg::result_t res;
  logic              q_full, q_not_empty, q_pop;
  logic              cfg_wr;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_ticks       <= swft_pkg::LONG_TICKS_RST;
      cfg_r.short_ticks      <= swft_pkg::SHORT_TICKS_RST;
      cfg_r.ack_sample_ticks <= swft_pkg::ACK_SAMPLE_RST;
      cfg_r.retry_gap_ticks  <= swft_pkg::RETRY_GAP_RST;
      cfg_r.retry_limit      <= swft_pkg::RETRY_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        swft_pkg::REG_LONG_TICKS:  cfg_r.long_ticks       <= pwdata[7:0];
        swft_pkg::REG_SHORT_TICKS: cfg_r.short_ticks      <= pwdata[7:0];
        swft_pkg::REG_ACK_SAMPLE:  cfg_r.ack_sample_ticks <= pwdata[7:0];
        swft_pkg::REG_RETRY_GAP:   cfg_r.retry_gap_ticks  <= pwdata[7:0];
        swft_pkg::REG_RETRY_LIMIT: cfg_r.retry_limit      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swft_pkg::REG_LONG_TICKS:  prdata = DW'(cfg_r.long_ticks);
      swft_pkg::REG_SHORT_TICKS: prdata = DW'(cfg_r.short_ticks);
      swft_pkg::REG_ACK_SAMPLE:  prdata = DW'(cfg_r.ack_sample_ticks);
      swft_pkg::REG_RETRY_GAP:   prdata = DW'(cfg_r.retry_gap_ticks);
      swft_pkg::REG_RETRY_LIMIT: prdata = DW'(cfg_r.retry_limit);
      default:                   prdata = '0;
    endcase
  end

  swft_front u_front (
    .in_command    (in_command),
    .in_payload    (in_payload),
    .in_line_level (in_line_level),
    .entry         (front_entry)
  );

  assign in_ready = !q_full;

  swft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_entry),
    .not_empty (q_not_empty)
  );

  swft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ent_valid (q_not_empty),
    .ent       (q_entry),
    .ent_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_drive_low      = res.drive_low;
  assign out_line_driven    = res.line_driven;
  assign out_busy_res       = res.busy_res;
  assign out_frame_done     = res.frame_done;
  assign out_frame_failed   = res.frame_failed;
  assign out_start_rejected = res.start_rejected;

endmodule

FILE: rtl/swft_checker.sv
// Port-level checks for the single-wire frame transmitter, bound to the top level.
module swft_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_drive_low,
  input logic out_line_driven,
  input logic out_busy_res,
  input logic out_frame_done,
  input logic out_frame_failed
);

  // a failure is always reported as the end of a frame
  a_fail_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_failed |-> out_frame_done)
    else $error("frame_failed without frame_done");

  // frame end is reported on an acknowledge-phase tick, line released
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_busy_res && !out_line_driven)
    else $error("frame_done outside acknowledge phase");

  // pulling low only happens inside a frame and push-pull
  a_low_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_low |-> out_line_driven && out_busy_res)
    else $error("drive_low while released or idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_low) &&
      $stable(out_line_driven) && $stable(out_frame_done))
    else $error("stalled result changed");

endmodule

bind single_wire_frame_transmitter_top swft_checker u_swft_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_drive_low    (out_drive_low),
  .out_line_driven  (out_line_driven),
  .out_busy_res     (out_busy_res),
  .out_frame_done   (out_frame_done),
  .out_frame_failed (out_frame_failed)
);

FILE: sim/single_wire_frame_transmitter_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the single-wire frame transmitter top level.
module single_wire_frame_transmitter_top_test;

  localparam int AW = swft_pkg::ADDR_W;
  localparam int DW = swft_pkg::DATA_W;
  localparam int FW = swft_pkg::FRAME_W;
  localparam int LW = swft_pkg::LEN_W;
  localparam int TW = swft_pkg::TICK_W;
  localparam int RW = swft_pkg::LIMIT_W;

  localparam logic [1:0]  CMD_SPARE     = 2'd3;   // unused code, behaves as a tick
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned PRINT_CAP     = 100;

  localparam swft_pkg::result_t RES_IDLE   = 6'b010000;  // line driven high, no flags
  localparam swft_pkg::result_t RES_FAILED = 6'b001110;  // released, busy, done with failure

  typedef enum logic [2:0] {
    LN_IDLE, LN_LOW, LN_HIGH, LN_EDGE, LN_DELAY, LN_GAP
  } line_phase_t;

  typedef enum logic [1:0] {ACK_GIVEN, ACK_WITHHELD, ACK_RANDOM} ack_plan_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [7:0]        payload;
    logic              line_level;
    logic              known;
    swft_pkg::result_t res;
  } request_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_command;
  logic [7:0]          in_payload;
  logic                in_line_level;
  logic                out_valid;
  logic                out_ready;
  logic                out_drive_low;
  logic                out_line_driven;
  logic                out_busy_res;
  logic                out_frame_done;
  logic                out_frame_failed;
  logic                out_start_rejected;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AW-1:0]       paddr;
  logic [DW-1:0]       pwdata;
  logic [DW-1:0]       prdata;
  logic                pready;

  single_wire_frame_transmitter_top u_top (.*);

  // line model state and register copy
  swft_pkg::cfg_t     line_cfg;
  line_phase_t        ln_phase;
  logic [FW-1:0]      ln_bits;
  logic [FW-1:0]      ln_saved;
  logic [LW-1:0]      ln_length;
  logic [LW-1:0]      ln_left;
  logic [TW-1:0]      ln_tick;
  logic [RW-1:0]      ln_attempts;

  swft_pkg::result_t tick_results_q[$];
  ack_plan_t   ack_plan;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned steady_left;
  bit          hold_request;

  string field_names [6] = '{"start_rejected", "frame_failed", "frame_done",
                             "busy_res", "line_driven", "drive_low"};
  int unsigned reg_resets [5] = '{40, 4, 24, 16, 1};

  request_row_t directed_rows [16] = '{
    '{swft_pkg::CMD_TICK,   8'h00, 1'b1, 1'b1, RES_IDLE},
    '{CMD_SPARE,            8'hFF, 1'b0, 1'b1, RES_IDLE},
    '{swft_pkg::CMD_START,  8'hFD, 1'b1, 1'b0, '0},      // code 5, upper bits ignored
    '{swft_pkg::DATA_START, 8'h00, 1'b1, 1'b0, '0},      // start while busy
    '{swft_pkg::CMD_TICK,   8'h55, 1'b0, 1'b0, '0},
    '{CMD_SPARE,            8'hAA, 1'b1, 1'b0, '0},
    '{swft_pkg::CMD_TICK,   8'h0F, 1'b0, 1'b0, '0},
    '{swft_pkg::CMD_TICK,   8'hF0, 1'b1, 1'b0, '0},
    '{swft_pkg::CMD_START,  8'h07, 1'b0, 1'b0, '0},
    '{swft_pkg::CMD_TICK,   8'h33, 1'b1, 1'b0, '0},
    '{swft_pkg::CMD_TICK,   8'hCC, 1'b0, 1'b0, '0},
    '{swft_pkg::CMD_TICK,   8'h00, 1'b1, 1'b0, '0},
    '{swft_pkg::CMD_TICK,   8'h80, 1'b1, 1'b0, '0},      // waiting for the target edge
    '{swft_pkg::CMD_TICK,   8'h01, 1'b0, 1'b0, '0},      // target pulls low
    '{swft_pkg::CMD_TICK,   8'h00, 1'b0, 1'b1, RES_FAILED},
    '{swft_pkg::CMD_TICK,   8'hFF, 1'b0, 1'b1, RES_IDLE}
  };

  swft_pkg::cfg_t phase_regs [5] = '{
    '{8'd3,   8'd1, 8'd2,   8'd2,   4'd3},
    '{8'd1,   8'd1, 8'd1,   8'd1,   4'd15},
    '{8'd255, 8'd0, 8'd255, 8'd255, 4'd1},
    '{8'd0,   8'd0, 8'd0,   8'd0,   4'd0},     // drawn at run time
    '{8'd6,   8'd2, 8'd5,   8'd3,   4'd4}
  };
  int unsigned phase_items [5] = '{300, 450, 550, 200, 200};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (mismatches < PRINT_CAP)
      $display("mismatch @%0d result %0d: %s got %0d want %0d",
               cycle_count, results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] v);
    return (v == '0) ? 8'd1 : v;
  endfunction

  // One tick of line time; updates the line model and returns what the tick shows.
  function automatic swft_pkg::result_t advance_line(input logic [1:0] cmd,
                                                     input logic [7:0] pl,
                                                     input logic lvl);
    swft_pkg::result_t r;
    r = '0;
    if (cmd == swft_pkg::CMD_START || cmd == swft_pkg::DATA_START) begin
      if (ln_phase == LN_IDLE) begin
        if (cmd == swft_pkg::CMD_START) begin
          ln_saved  = {1'b0, pl[2:0], ^pl[2:0], 5'b0};
          ln_length = swft_pkg::CMD_FRAME_LEN;
        end else begin
          ln_saved  = {1'b0, pl, ^pl};
          ln_length = swft_pkg::DATA_FRAME_LEN;
        end
        ln_bits     = ln_saved;
        ln_left     = ln_length;
        ln_attempts = (line_cfg.retry_limit == '0) ? 4'd1 : line_cfg.retry_limit;
        ln_tick     = '0;
        ln_phase    = LN_LOW;
      end else begin
        r.start_rejected = 1'b1;
      end
    end
    case (ln_phase)
      LN_LOW: begin
        r.drive_low   = 1'b1;
        r.line_driven = 1'b1;
        r.busy_res    = 1'b1;
        ln_tick = ln_tick + 1'b1;
        if (ln_tick >= at_least_one(ln_bits[FW-1] ? line_cfg.short_ticks
                                                  : line_cfg.long_ticks)) begin
          ln_tick  = '0;
          ln_phase = LN_HIGH;
        end
      end
      LN_HIGH: begin
        r.line_driven = 1'b1;
        r.busy_res    = 1'b1;
        ln_tick = ln_tick + 1'b1;
        if (ln_tick >= at_least_one(ln_bits[FW-1] ? line_cfg.long_ticks
                                                  : line_cfg.short_ticks)) begin
          ln_tick = '0;
          ln_bits = ln_bits << 1;
          if (ln_left != '0) ln_left = ln_left - 1'b1;
          ln_phase = (ln_left != '0) ? LN_LOW : LN_EDGE;
        end
      end
      LN_EDGE: begin
        r.busy_res = 1'b1;
        if (!lvl) begin
          ln_tick  = '0;
          ln_phase = LN_DELAY;
        end
      end
      LN_DELAY: begin
        r.busy_res = 1'b1;
        ln_tick = ln_tick + 1'b1;
        if (ln_tick >= at_least_one(line_cfg.ack_sample_ticks)) begin
          ln_tick = '0;
          if (lvl) begin
            r.frame_done = 1'b1;
            ln_phase = LN_IDLE;
          end else begin
            if (ln_attempts != '0) ln_attempts = ln_attempts - 1'b1;
            if (ln_attempts == '0) begin
              r.frame_done   = 1'b1;
              r.frame_failed = 1'b1;
              ln_phase = LN_IDLE;
            end else begin
              ln_phase = LN_GAP;
            end
          end
        end
      end
      LN_GAP: begin
        r.busy_res = 1'b1;
        ln_tick = ln_tick + 1'b1;
        if (ln_tick >= at_least_one(line_cfg.retry_gap_ticks)) begin
          ln_tick  = '0;
          ln_bits  = ln_saved;
          ln_left  = ln_length;
          ln_phase = LN_LOW;
        end
      end
      default: begin
        r.line_driven = 1'b1;
        ln_phase = LN_IDLE;
      end
    endcase
    return r;
  endfunction

  // Mostly well-formed frames; the line level follows the per-frame ack plan.
  task automatic pick_request(input bit short_frames, output logic [1:0] c,
                              output logic [7:0] p, output logic l);
    int unsigned r;
    p = 8'($urandom_range(0, 255));
    l = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (ln_phase == LN_IDLE) begin
      if (r < 80) begin
        c = (short_frames || r[0]) ? swft_pkg::CMD_START : swft_pkg::DATA_START;
        ack_plan = ack_plan_t'($urandom_range(0, 2));
      end else begin
        c = r[0] ? swft_pkg::CMD_TICK : CMD_SPARE;
      end
    end else begin
      if (r < 4)
        c = r[0] ? swft_pkg::CMD_START : swft_pkg::DATA_START;
      else if (r < 8)
        c = CMD_SPARE;
      else
        c = swft_pkg::CMD_TICK;
      if (ln_phase == LN_EDGE)
        l = ($urandom_range(0, 2) != 0);
      else if (ln_phase == LN_DELAY && ack_plan != ACK_RANDOM &&
               ln_tick + 1 >= at_least_one(line_cfg.ack_sample_ticks))
        l = (ack_plan == ACK_GIVEN);
    end
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (steady_left != 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 54) steady_left = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [1:0] c, input logic [7:0] p, input logic l,
                              input logic known, input swft_pkg::result_t fixed_res,
                              input int unsigned gap);
    swft_pkg::result_t predicted;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= c;
    in_payload    <= p;
    in_line_level <= l;
    do @(posedge clk); while (!in_ready);
    predicted = advance_line(c, p, l);
    tick_results_q.push_back(known ? fixed_res : predicted);
  endtask

  task automatic wait_for_results();
    while (tick_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      swft_pkg::REG_LONG_TICKS:  line_cfg.long_ticks       = value;
      swft_pkg::REG_SHORT_TICKS: line_cfg.short_ticks      = value;
      swft_pkg::REG_ACK_SAMPLE:  line_cfg.ack_sample_ticks = value;
      swft_pkg::REG_RETRY_GAP:   line_cfg.retry_gap_ticks  = value;
      swft_pkg::REG_RETRY_LIMIT: line_cfg.retry_limit      = value[RW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Caller has already lowered in_valid.
  task automatic program_phase(input swft_pkg::cfg_t regs);
    wait_for_results();
    write_reg(swft_pkg::REG_LONG_TICKS,  regs.long_ticks);
    write_reg(swft_pkg::REG_SHORT_TICKS, regs.short_ticks);
    write_reg(swft_pkg::REG_ACK_SAMPLE,  regs.ack_sample_ticks);
    write_reg(swft_pkg::REG_RETRY_GAP,   regs.retry_gap_ticks);
    write_reg(swft_pkg::REG_RETRY_LIMIT, 8'(regs.retry_limit));
  endtask

  always @(posedge clk) begin
    swft_pkg::result_t got_res;
    swft_pkg::result_t want_res;
    if (rst_n && out_valid && out_ready) begin
      got_res = {out_drive_low, out_line_driven, out_busy_res,
                 out_frame_done, out_frame_failed, out_start_rejected};
      if (tick_results_q.size() == 0) begin
        flag_mismatch("result with no request pending", 32'(got_res), 0);
      end else begin
        want_res = tick_results_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (got_res[i] !== want_res[i])
            flag_mismatch(field_names[i], 32'(got_res[i]), 32'(want_res[i]));
      end
      results_seen++;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int unsigned n;
    int unsigned r;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 30);
        end else begin
          out_ready <= 1'b0;
          n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(15, 50);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    logic [1:0]     c;
    logic [7:0]     p;
    logic           l;
    swft_pkg::cfg_t regs;
    int unsigned    waited;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = swft_pkg::CMD_TICK;
    in_payload    = '0;
    in_line_level = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatches    = 0;
    results_seen  = 0;
    cycle_count   = 0;
    steady_left   = 0;
    hold_request  = 1'b0;
    ack_plan      = ACK_GIVEN;
    line_cfg    = '{swft_pkg::LONG_TICKS_RST, swft_pkg::SHORT_TICKS_RST,
                    swft_pkg::ACK_SAMPLE_RST, swft_pkg::RETRY_GAP_RST,
                    swft_pkg::RETRY_LIMIT_RST};
    ln_phase    = LN_IDLE;
    ln_bits     = '0;
    ln_saved    = '0;
    ln_length   = '0;
    ln_left     = '0;
    ln_tick     = '0;
    ln_attempts = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers must read back their reset values
    for (int i = 0; i < 5; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= AW'(i * 4);
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== DW'(reg_resets[i]))
        flag_mismatch("register reset value", prdata, reg_resets[i]);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end

    // zero in every register must behave as one
    program_phase('0);
    foreach (directed_rows[i])
      send_request(directed_rows[i].command, directed_rows[i].payload,
                   directed_rows[i].line_level, directed_rows[i].known,
                   directed_rows[i].res, sender_gap());
    in_valid <= 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      regs = phase_regs[ph];
      if (ph == 3)
        regs = '{8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                 8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                 4'($urandom_range(0, 15))};
      program_phase(regs);
      for (int k = 0; k < phase_items[ph]; k++) begin
        // command frames only while the bit phases are at their longest
        pick_request(ph == 2, c, p, l);
        if (ph == 0 && k == 120) begin
          in_valid <= 1'b0;
          wait_for_results();
        end
        if (ph == 1 && k == 60) hold_request = 1'b1;
        send_request(c, p, l, 1'b0, '0, sender_gap());
      end
      in_valid <= 1'b0;
    end

    waited = 0;
    while (tick_results_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tick_results_q.size() != 0)
      flag_mismatch("requests left without result", tick_results_q.size(), 0);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/swft_pkg.sv
rtl/swft_front.sv
rtl/swft_queue.sv
rtl/swft_back.sv
rtl/single_wire_frame_transmitter_top.sv
rtl/swft_checker.sv
sim/single_wire_frame_transmitter_top_test.sv
